// ===== rtl/core/rcpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpe_pkg
// Shared types and constants for the remote code pulse encoder: control word
// layout of the sequencer program, jump conditions and pulse multipliers.
// ----------------------------------------------------------------------------
package rcpe_pkg;

    localparam int DATA_W  = 62;             // serial (58) above button (4)
    localparam int SER_W   = 58;
    localparam int BTN_W   = 4;
    localparam int TE_W    = 16;
    localparam int TIME_W  = 19;
    localparam int FBITS_W = 6;
    localparam int IDX_W   = $clog2(DATA_W);
    localparam logic [TE_W-1:0] TE_RESET = 16'd320;

    // bit count limits: data word width caps the count
    localparam int MAX_BITS     = 62;
    localparam int DEFAULT_BITS = 24;

    // register indexes
    localparam logic CFG_BASE_PERIOD = 1'b0;
    localparam logic CFG_FRAME_BITS  = 1'b1;

    // segment kinds
    typedef enum logic [1:0] {
        KIND_PREAMBLE = 2'd0,
        KIND_ZERO     = 2'd1,
        KIND_ONE      = 2'd2,
        KIND_FOOTER   = 2'd3
    } t_kind;

    // multiples of te
    typedef enum logic [2:0] {
        MUL_1 = 3'd0,
        MUL_2 = 3'd1,
        MUL_3 = 3'd2,
        MUL_4 = 3'd3,
        MUL_6 = 3'd4,
        MUL_8 = 3'd5
    } t_mul;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,   // fall through
        COND_ALWAYS   = 2'd1,
        COND_NO_START = 2'd2,   // jump while no frame has started
        COND_MORE     = 2'd3    // jump while data bits remain
    } t_cond;

    typedef logic [1:0] t_step;

    localparam t_step STEP_IDLE   = 2'd0;
    localparam t_step STEP_PRE    = 2'd1;
    localparam t_step STEP_DATA   = 2'd2;
    localparam t_step STEP_FOOTER = 2'd3;

    typedef struct packed {
        logic  take;      // accept a frame request, load data and count
        logic  emit;      // write a pair to the output register
        logic  use_bit;   // pair shape chosen by the current data bit
        logic  dec;       // count down one data bit
        t_mul  hi_mul;
        t_mul  lo_mul;
        t_kind kind;
        logic  last;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic start;      // request taken with a non-zero time unit
        logic more;       // further data bits after the current one
        logic stall;      // emit step blocked by a full output register
    } t_flags;

    function automatic logic [TIME_W-1:0] te_times(input logic [TE_W-1:0] te,
                                                   input t_mul m);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] r;
        t = TIME_W'(te);
        case (m)
            MUL_1:   r = t;
            MUL_2:   r = t << 1;
            MUL_3:   r = (t << 1) + t;
            MUL_4:   r = t << 2;
            MUL_6:   r = (t << 2) + (t << 1);
            MUL_8:   r = t << 3;
            default: r = t;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/remote_code_pulse_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The step after the request transaction writes the preamble pair to the output register.
// Throughput: one pair per cycle while the output register is free; a full one stalls the
//   sequencer. Frames run the four-step microcode loop (idle, preamble, N data steps, footer).
// A request taken while base_period is zero yields nothing.
// Reset (synchronous, active low): sequencer to idle, output empty,
//   base_period = 320, frame_bits = 0.
// ----------------------------------------------------------------------------
// remote_code_pulse_encoder_unit
// Fixed-code pulse-width remote encoder: turns one frame request into a
// preamble, one mark/space pair per data bit (MSB first) and a footer.
// ----------------------------------------------------------------------------
module remote_code_pulse_encoder_unit
    import rcpe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [57:0] serial_number, [61:58] button_code
    // pair stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [18:0] high_time, [37:19] low_time
    output logic [1:0]       m_tuser,   // [1:0] segment_kind
    output logic             m_tlast    // last_pair
);

    // configuration registers
    logic [TE_W-1:0]    r_te;
    logic [FBITS_W-1:0] r_frame_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_te         <= TE_RESET;
            r_frame_bits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_PERIOD: r_te         <= i_cfg_wdata;
                CFG_FRAME_BITS:  r_frame_bits <= i_cfg_wdata[FBITS_W-1:0];
                default:         r_te         <= r_te;
            endcase
        end
    end

    // sequencer
    t_ctrl  w_ctrl;
    t_flags w_flags;
    logic   w_accept;
    logic   w_out_free;

    rcpe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // datapath: data word and remaining bit count
    logic [DATA_W-1:0]  r_data;
    logic [FBITS_W-1:0] r_cnt;
    logic [FBITS_W-1:0] w_bits;
    logic [IDX_W-1:0]   w_idx;
    logic               w_bit;

    assign s_tready   = w_ctrl.take;
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !m_tvalid || m_tready;

    assign w_flags.start = w_accept && (r_te != '0);
    assign w_flags.more  = (r_cnt != FBITS_W'(1));
    assign w_flags.stall = w_ctrl.emit && !w_out_free;

    // zero selects the default count, large counts saturate
    always_comb begin
        if (r_frame_bits == '0) begin
            w_bits = FBITS_W'(DEFAULT_BITS);
        end else if (r_frame_bits > FBITS_W'(MAX_BITS)) begin
            w_bits = FBITS_W'(MAX_BITS);
        end else begin
            w_bits = r_frame_bits;
        end
    end

    assign w_idx = IDX_W'(r_cnt - FBITS_W'(1));
    assign w_bit = r_data[w_idx];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // button in the low nibble, serial above it
            r_data <= {s_tdata[SER_W-1:0], s_tdata[SER_W+BTN_W-1:SER_W]};
            r_cnt  <= w_bits;
        end else if (w_ctrl.dec && !w_flags.stall) begin
            r_cnt  <= r_cnt - FBITS_W'(1);
        end
    end

    // output register parts the sequencer from the consumer
    t_mul              w_hi_mul;
    t_mul              w_lo_mul;
    t_kind             w_kind;
    logic [TIME_W-1:0] r_high;
    logic [TIME_W-1:0] r_low;
    t_kind             r_kind;
    logic              r_last;
    logic              r_out_valid;

    always_comb begin
        if (w_ctrl.use_bit && w_bit) begin
            w_hi_mul = MUL_3;
            w_lo_mul = MUL_1;
            w_kind   = KIND_ONE;
        end else begin
            w_hi_mul = w_ctrl.hi_mul;
            w_lo_mul = w_ctrl.lo_mul;
            w_kind   = w_ctrl.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit && w_out_free) begin
            r_high <= te_times(r_te, w_hi_mul);
            r_low  <= te_times(r_te, w_lo_mul);
            r_kind <= w_kind;
            r_last <= w_ctrl.last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_low, r_high};
    assign m_tuser  = r_kind;
    assign m_tlast  = r_last;

endmodule
`default_nettype wire

// ===== rtl/core/rcpe_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpe_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module rcpe_seq
    import rcpe_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_ctrl       o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_jump;

    // program: idle/load, preamble, data loop, footer
    function automatic t_ctrl rom(input t_step s);
        t_ctrl c;
        c = '{take: 1'b0, emit: 1'b0, use_bit: 1'b0, dec: 1'b0,
              hi_mul: MUL_1, lo_mul: MUL_1, kind: KIND_PREAMBLE, last: 1'b0,
              cond: COND_NONE, target: STEP_IDLE};
        case (s)
            STEP_IDLE: begin
                c.take   = 1'b1;
                c.cond   = COND_NO_START;
                c.target = STEP_IDLE;
            end
            STEP_PRE: begin
                c.emit   = 1'b1;
                c.hi_mul = MUL_8;
                c.lo_mul = MUL_4;
                c.kind   = KIND_PREAMBLE;
            end
            STEP_DATA: begin
                c.emit    = 1'b1;
                c.use_bit = 1'b1;
                c.dec     = 1'b1;
                c.hi_mul  = MUL_1;
                c.lo_mul  = MUL_2;
                c.kind    = KIND_ZERO;
                c.cond    = COND_MORE;
                c.target  = STEP_DATA;
            end
            STEP_FOOTER: begin
                c.emit   = 1'b1;
                c.hi_mul = MUL_1;
                c.lo_mul = MUL_6;
                c.kind   = KIND_FOOTER;
                c.last   = 1'b1;
                c.cond   = COND_ALWAYS;
                c.target = STEP_IDLE;
            end
            default: c.cond = COND_ALWAYS;
        endcase
        return c;
    endfunction

    always_comb begin
        w_ctrl = rom(r_step);
        case (w_ctrl.cond)
            COND_NONE:     w_jump = 1'b0;
            COND_ALWAYS:   w_jump = 1'b1;
            COND_NO_START: w_jump = !i_flags.start;
            COND_MORE:     w_jump = i_flags.more;
            default:       w_jump = 1'b0;
        endcase
        if (i_flags.stall) begin
            n_step = r_step;
        end else if (w_jump) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule
`default_nettype wire
